FILE: sv/tacm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tacm_pkg
// shared types and constants of the tilt calibrate, clamp and map core
// ----------------------------------------------------------------------------
package tacm_pkg;

    // limits after reset
    localparam int LIMIT_LOW_RESET  = 370;
    localparam int LIMIT_HIGH_RESET = 590;

    // map sequence: new bar/dot, new tilt, old bar/dot
    localparam int MAP_IDX_W     = 4;
    localparam int MAP_COUNT     = 10;
    localparam int MAP_X_TILT    = 4;
    localparam int MAP_Y_TILT    = 5;
    localparam int MAP_OLD_FIRST = 6;

    localparam int POS_W   = 6;
    localparam int POS_MAX = 63;

    // x bar, y bar, x dot, y dot: start and end of each range
    localparam logic [POS_W-1:0] POS_START [4] = '{6'd3, 6'd35, 6'd5, 6'd33};
    localparam logic [POS_W-1:0] POS_END   [4] = '{6'd46, 6'd2, 6'd33, 6'd5};

    typedef enum logic [2:0] {
        MODE_RUN    = 3'd0,
        MODE_CENTRE = 3'd1,
        MODE_BACK   = 3'd2,
        MODE_FRONT  = 3'd3,
        MODE_RIGHT  = 3'd4,
        MODE_LEFT   = 3'd5,
        MODE_DONE   = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_START,
        ST_WAIT,
        ST_STORE,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } div_stat_t;

endpackage
`default_nettype wire

FILE: sv/tacm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tacm_div
// iterative restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tacm_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [NUM_W-1:0]   num,
    input  wire logic [DEN_W-1:0]   den,
    output logic      [NUM_W-1:0]   quo,
    output tacm_pkg::div_stat_t     stat
);
    import tacm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(NUM_W);
            quo_next = num;
            rem_next = '0;
            den_next = den;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo         = quo_reg;
    assign stat.done   = done_reg;
    assign stat.rem_nz = |rem_reg;

endmodule
`default_nettype wire

FILE: sv/tilt_axis_calibrate_clamp_map_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_axis_calibrate_clamp_map_core
// calibrates, clamps and maps averaged two-axis tilt samples
// ----------------------------------------------------------------------------
// Each request carries one averaged x/y sample and a calibrate flag and gives
// exactly one result. The calibrate flag starts a six-step sequence that
// captures the axis limits, one step per request. A sample equal to the
// stored previous one returns zero coordinates.
// A changed sample runs ten integer maps through one multiplier and one shared
// bit-serial divider of NUM_W = max(SAMPLE_BITS, 10) + TILT_FRAC_BITS + 2
// bits; a map skips the divider when the span of its axis is zero or
// inverted. The input side is ready only between items; a finished result
// waits in the output register while the next request is taken.
module tilt_axis_calibrate_clamp_map_core #(
    parameter int SAMPLE_BITS    = 10,
    parameter int TILT_FRAC_BITS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // x_sample, y_sample
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // cal_request
    input  wire logic s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // x_bar, y_bar, x_dot, y_dot, x_tilt, y_tilt,
    // old_x_bar, old_y_bar, old_x_dot, old_y_dot
    output logic [((48+2*(TILT_FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    // changed, mode
    output logic [3:0] m_axis_tuser
);
    import tacm_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int LW    = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;
    localparam int TW    = TILT_FRAC_BITS + 2;
    localparam int CMW   = TILT_FRAC_BITS + 2;
    localparam int NW    = LW + CMW;
    localparam int RW    = NW + 3;
    localparam int OUT_W = ((48 + 2*TW + 7) / 8) * 8;

    state_t state_reg, state_next;

    logic                 cal_active_reg, cal_active_next;
    logic [2:0]           cal_stage_reg, cal_stage_next;
    logic [LW-1:0]        x_lo_reg, x_lo_next, x_hi_reg, x_hi_next;
    logic [LW-1:0]        y_lo_reg, y_lo_next, y_hi_reg, y_hi_next;
    logic [LW-1:0]        x_last_reg, y_last_reg;
    mode_t                mode_reg, mode_next;
    logic [SB-1:0]        x_in_reg, y_in_reg;
    logic [LW-1:0]        xn_reg, yn_reg;
    logic                 changed_reg;
    logic [MAP_IDX_W-1:0] idx_reg;
    logic [NW-1:0]        prod_reg;
    logic [LW-1:0]        span_reg;
    logic                 neg_reg, degen_reg;
    logic [POS_W-1:0]     pos_reg [8];
    logic [TW-1:0]        tilt_reg [2];
    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_data_reg;
    logic [3:0]           m_user_reg;

    logic          accept;
    logic          out_free;
    logic          div_start;
    logic [SB-1:0] x_raw, y_raw;

    // operand selection for the current map
    logic                   sel_y, is_new, is_tilt, coef_neg;
    logic [1:0]             kind;
    logic [LW-1:0]          v, lo, hi;
    logic signed [LW:0]     d;
    logic [LW-1:0]          d_mag;
    logic [CMW-1:0]         coef_mag;
    logic [LW-1:0]          x_ext, y_ext, xn_c, yn_c;
    logic                   changed_c;

    // result forming
    logic [NW-1:0]          div_quo;
    div_stat_t              div_stat;
    logic [RW-1:0]          mag;
    logic signed [RW-1:0]   qs, a_ext, res;
    logic [POS_W-1:0]       pos_val;
    logic [2:0]             slot;

    assign x_raw    = s_axis_tdata[SB-1:0];
    assign y_raw    = s_axis_tdata[2*SB-1:SB];
    assign out_free = !m_valid_reg || m_axis_tready;
    assign accept   = s_axis_tvalid && s_axis_tready;

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_axis_tvalid) state_next = ST_SETUP;
            ST_SETUP: state_next = changed_c ? ST_MUL : ST_FIN;
            ST_MUL:   state_next = (hi <= lo) ? ST_STORE : ST_START;
            ST_START: state_next = ST_WAIT;
            ST_WAIT:  if (div_stat.done) state_next = ST_STORE;
            ST_STORE: state_next = (idx_reg == MAP_IDX_W'(MAP_COUNT - 1)) ? ST_FIN : ST_MUL;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_START: div_start     = 1'b1;
            default:  ;
        endcase
    end

    // ---------------- calibration sequence ----------------
    always_comb
    begin
        cal_active_next = cal_active_reg;
        cal_stage_next  = cal_stage_reg;
        x_lo_next       = x_lo_reg;
        x_hi_next       = x_hi_reg;
        y_lo_next       = y_lo_reg;
        y_hi_next       = y_hi_reg;
        mode_next       = mode_reg;
        if (accept)
        begin
            mode_next = MODE_RUN;
            if (cal_active_reg || s_axis_tuser)
            begin
                cal_active_next = 1'b1;
                cal_stage_next  = cal_stage_reg + 3'd1;
                unique case (cal_stage_reg)
                    3'd0: mode_next = MODE_CENTRE;
                    3'd1: mode_next = MODE_BACK;
                    3'd2:
                    begin
                        mode_next = MODE_FRONT;
                        y_hi_next = LW'(y_raw);
                    end
                    3'd3:
                    begin
                        mode_next = MODE_RIGHT;
                        y_lo_next = LW'(y_raw);
                    end
                    3'd4:
                    begin
                        mode_next = MODE_LEFT;
                        x_hi_next = LW'(x_raw);
                    end
                    default:
                    begin
                        mode_next       = MODE_DONE;
                        x_lo_next       = LW'(x_raw);
                        cal_stage_next  = 3'd0;
                        cal_active_next = 1'b0;
                    end
                endcase
            end
        end
    end

    // ---------------- clamp and change detect ----------------
    assign x_ext     = LW'(x_in_reg);
    assign y_ext     = LW'(y_in_reg);
    assign xn_c      = (x_ext >= x_hi_reg) ? x_hi_reg : ((x_ext <= x_lo_reg) ? x_lo_reg : x_ext);
    assign yn_c      = (y_ext >= y_hi_reg) ? y_hi_reg : ((y_ext <= y_lo_reg) ? y_lo_reg : y_ext);
    assign changed_c = (x_ext != x_last_reg) || (y_ext != y_last_reg);

    // ---------------- map operand selection ----------------
    always_comb
    begin
        sel_y   = idx_reg[0];
        is_new  = (idx_reg < MAP_IDX_W'(MAP_OLD_FIRST));
        is_tilt = (idx_reg == MAP_IDX_W'(MAP_X_TILT)) || (idx_reg == MAP_IDX_W'(MAP_Y_TILT));
        kind    = is_new ? idx_reg[1:0] : 2'(idx_reg - MAP_IDX_W'(MAP_OLD_FIRST));
        lo      = sel_y ? y_lo_reg : x_lo_reg;
        hi      = sel_y ? y_hi_reg : x_hi_reg;
        if (is_new)
            v = sel_y ? yn_reg : xn_reg;
        else
            v = sel_y ? y_last_reg : x_last_reg;
        d     = $signed({1'b0, v}) - $signed({1'b0, lo});
        d_mag = (d < 0) ? LW'(-d) : LW'(d);
        if (is_tilt)
        begin
            coef_neg = 1'b0;
            coef_mag = CMW'(1) << (TILT_FRAC_BITS + 1);
        end
        else if (POS_END[kind] < POS_START[kind])
        begin
            coef_neg = 1'b1;
            coef_mag = CMW'(POS_START[kind] - POS_END[kind]);
        end
        else
        begin
            coef_neg = 1'b0;
            coef_mag = CMW'(POS_END[kind] - POS_START[kind]);
        end
    end

    tacm_div #(
        .NUM_W (NW),
        .DEN_W (LW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (span_reg),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    // ---------------- floor correction and saturation ----------------
    always_comb
    begin
        mag = RW'(div_quo) + RW'(neg_reg && div_stat.rem_nz);
        if (degen_reg)
            qs = '0;
        else if (neg_reg)
            qs = -$signed(mag);
        else
            qs = $signed(mag);
        if (is_tilt)
            a_ext = -$signed(RW'(1) << TILT_FRAC_BITS);
        else
            a_ext = $signed(RW'(POS_START[kind]));
        res = a_ext + qs;
        if (res < 0)
            pos_val = '0;
        else if (res > $signed(RW'(POS_MAX)))
            pos_val = POS_W'(POS_MAX);
        else
            pos_val = res[POS_W-1:0];
        slot = is_new ? idx_reg[2:0] : 3'(idx_reg - MAP_IDX_W'(2));
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cal_active_reg <= 1'b0;
            cal_stage_reg  <= 3'd0;
            x_lo_reg       <= LW'(LIMIT_LOW_RESET);
            x_hi_reg       <= LW'(LIMIT_HIGH_RESET);
            y_lo_reg       <= LW'(LIMIT_LOW_RESET);
            y_hi_reg       <= LW'(LIMIT_HIGH_RESET);
            x_last_reg     <= '0;
            y_last_reg     <= '0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cal_active_reg <= cal_active_next;
            cal_stage_reg  <= cal_stage_next;
            x_lo_reg       <= x_lo_next;
            x_hi_reg       <= x_hi_next;
            y_lo_reg       <= y_lo_next;
            y_hi_reg       <= y_hi_next;
            if (state_reg == ST_SETUP)
                idx_reg <= '0;
            else if (state_reg == ST_STORE)
                idx_reg <= idx_reg + MAP_IDX_W'(1);
            if (state_reg == ST_FIN && out_free && changed_reg)
            begin
                x_last_reg <= xn_reg;
                y_last_reg <= yn_reg;
            end
            if (state_reg == ST_FIN && out_free)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        if (accept)
        begin
            x_in_reg <= x_raw;
            y_in_reg <= y_raw;
        end
        if (state_reg == ST_SETUP)
        begin
            xn_reg      <= xn_c;
            yn_reg      <= yn_c;
            changed_reg <= changed_c;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg  <= NW'(coef_mag * d_mag);
            neg_reg   <= coef_neg ^ (d < 0);
            span_reg  <= hi - lo;
            degen_reg <= (hi <= lo);
        end
        if (state_reg == ST_STORE)
        begin
            if (is_tilt)
                tilt_reg[idx_reg[0]] <= res[TW-1:0];
            else
                pos_reg[slot] <= pos_val;
        end
        if (state_reg == ST_FIN && out_free)
        begin
            m_user_reg <= {mode_reg, changed_reg};
            if (changed_reg)
                m_data_reg <= OUT_W'({pos_reg[7], pos_reg[6], pos_reg[5], pos_reg[4],
                                      tilt_reg[1], tilt_reg[0],
                                      pos_reg[3], pos_reg[2], pos_reg[1], pos_reg[0]});
            else
                m_data_reg <= '0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule
`default_nettype wire
